// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the Q24.8 fixed-point ALU.
// Each macro builds one clocked concurrent assertion, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// when ante holds, cons must hold in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/q24alu_pkg.sv =====
// Shared types and operation codes of the Q24.8 fixed-point ALU.
// No dependencies; every other RTL file but assert_macros.svh depends on it.
`default_nettype none

package q24alu_pkg;

    localparam int KIND_W = 4;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_ADD = 4'd0;
    localparam kind_t KIND_SUB = 4'd1;
    localparam kind_t KIND_MUL = 4'd2;
    localparam kind_t KIND_DIV = 4'd3;
    localparam kind_t KIND_MIN = 4'd4;
    localparam kind_t KIND_MAX = 4'd5;
    localparam kind_t KIND_CMP = 4'd6;
    localparam kind_t KIND_INC = 4'd7;
    localparam kind_t KIND_DEC = 4'd8;
    localparam kind_t KIND_I2F = 4'd9;
    localparam kind_t KIND_F2I = 4'd10;

    // control that travels with each beat along the divider chain
    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg;
        logic dz;
        logic less;
        logic equal;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/q24alu_if.sv =====
// Valid/ready channel interfaces of the Q24.8 fixed-point ALU: operation in, result out.
// Depends on q24alu_pkg for the operation code type.
`default_nettype none

interface q24alu_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    q24alu_pkg::kind_t           kind;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b,
                    output ready);
endinterface

interface q24alu_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] result;
    logic                        less;
    logic                        equal;
    logic                        div_zero;

    modport source (output valid, output result, output less, output equal,
                    output div_zero, input ready);
    modport sink   (input valid, input result, input less, input equal,
                    input div_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/q24alu_front.sv =====
// Front end of the ALU: input register, then all non-divide operations,
// the multiplier and the divider setup. Depends on q24alu_pkg and q24alu_if.
`default_nettype none
`include "assert_macros.svh"

module q24alu_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    q24alu_in_if.sink                             op,
    output q24alu_pkg::ctl_t                      ctl,
    output logic [WORD_BITS-1:0]                  result,
    output logic [WORD_BITS-1:0]                  rem,
    output logic [WORD_BITS+FRAC_BITS-1:0]        dq,
    output logic [WORD_BITS-1:0]                  divisor
);
    import q24alu_pkg::*;

    localparam int DW = WORD_BITS + FRAC_BITS;

    // input stage
    logic                 a_valid_reg;
    kind_t                kind_reg;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;

    // compute stage
    ctl_t                 ctl_reg;
    ctl_t                 ctl_next;
    logic [WORD_BITS-1:0] result_reg;
    logic [WORD_BITS-1:0] result_next;
    logic [DW-1:0]        dq_reg;
    logic [DW-1:0]        dq_next;
    logic [WORD_BITS-1:0] divisor_reg;
    logic [WORD_BITS-1:0] divisor_next;

    logic signed [2*WORD_BITS-1:0] prod;
    logic [WORD_BITS-1:0]          mag_a;
    logic [WORD_BITS-1:0]          mag_b;
    logic [WORD_BITS-1:0]          f2i_mag;
    logic                          lt;
    logic                          eq;

    assign op.ready = adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end
        else if (adv) begin
            a_valid_reg <= op.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            kind_reg <= op.kind;
            a_reg    <= op.operand_a;
            b_reg    <= op.operand_b;
        end
    end

    assign prod    = $signed(a_reg) * $signed(b_reg);
    assign mag_a   = a_reg[WORD_BITS-1] ? (~a_reg + WORD_BITS'(1)) : a_reg;
    assign mag_b   = b_reg[WORD_BITS-1] ? (~b_reg + WORD_BITS'(1)) : b_reg;
    assign f2i_mag = mag_a >> FRAC_BITS;
    assign lt      = $signed(a_reg) < $signed(b_reg);
    assign eq      = (a_reg == b_reg);

    always_comb begin
        ctl_next.valid  = a_valid_reg;
        ctl_next.is_div = (kind_reg == KIND_DIV);
        ctl_next.neg    = a_reg[WORD_BITS-1] ^ b_reg[WORD_BITS-1];
        ctl_next.dz     = (kind_reg == KIND_DIV) && (b_reg == '0);
        ctl_next.less   = lt;
        ctl_next.equal  = eq;

        // dividend is |a| scaled up by the fraction bits; quotient shifts in below
        dq_next      = {mag_a, {FRAC_BITS{1'b0}}};
        divisor_next = mag_b;

        unique case (kind_reg)
            KIND_ADD: result_next = a_reg + b_reg;
            KIND_SUB: result_next = a_reg - b_reg;
            KIND_MUL: result_next = prod[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
            KIND_MIN: result_next = (lt || eq) ? a_reg : b_reg;
            KIND_MAX: result_next = lt ? b_reg : a_reg;
            KIND_INC: result_next = a_reg + WORD_BITS'(1);
            KIND_DEC: result_next = a_reg - WORD_BITS'(1);
            KIND_I2F: result_next = a_reg << FRAC_BITS;
            KIND_F2I: result_next = a_reg[WORD_BITS-1] ? (~f2i_mag + WORD_BITS'(1))
                                                       : f2i_mag;
            default:  result_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end
        else if (adv) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            result_reg  <= result_next;
            dq_reg      <= dq_next;
            divisor_reg <= divisor_next;
        end
    end

    assign ctl     = ctl_reg;
    assign result  = result_reg;
    assign rem     = '0;
    assign dq      = dq_reg;
    assign divisor = divisor_reg;

    `ASSERT_IMPLY(a_dz_only_on_div, clk, rst_n, ctl_reg.dz, ctl_reg.is_div)
    `ASSERT_NEXT(a_front_holds_on_stall, clk, rst_n, !adv, ctl_reg == $past(ctl_reg))

endmodule

`default_nettype wire

// ===== rtl/q24alu_div_cell.sv =====
// One cell of the divider chain: a single restoring quotient step per beat,
// other beat contents passed along unchanged. Depends on q24alu_pkg.
`default_nettype none
`include "assert_macros.svh"

module q24alu_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire q24alu_pkg::ctl_t                  ctl_in,
    input  wire logic [WORD_BITS-1:0]              result_in,
    input  wire logic [WORD_BITS-1:0]              rem_in,
    input  wire logic [WORD_BITS+FRAC_BITS-1:0]    dq_in,
    input  wire logic [WORD_BITS-1:0]              divisor_in,
    output q24alu_pkg::ctl_t                       ctl_out,
    output logic [WORD_BITS-1:0]                   result_out,
    output logic [WORD_BITS-1:0]                   rem_out,
    output logic [WORD_BITS+FRAC_BITS-1:0]         dq_out,
    output logic [WORD_BITS-1:0]                   divisor_out
);
    import q24alu_pkg::*;

    localparam int DW = WORD_BITS + FRAC_BITS;

    ctl_t                 ctl_reg;
    logic [WORD_BITS-1:0] result_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] rem_next;
    logic [DW-1:0]        dq_reg;
    logic [DW-1:0]        dq_next;
    logic [WORD_BITS-1:0] divisor_reg;

    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    // bring down the next dividend bit, subtract if it fits
    assign trial = {rem_in, dq_in[DW-1]};
    assign diff  = trial - {1'b0, divisor_in};
    assign ge    = (trial >= {1'b0, divisor_in});

    assign rem_next = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    assign dq_next  = {dq_in[DW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end
        else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            result_reg  <= result_in;
            rem_reg     <= rem_next;
            dq_reg      <= dq_next;
            divisor_reg <= divisor_in;
        end
    end

    assign ctl_out     = ctl_reg;
    assign result_out  = result_reg;
    assign rem_out     = rem_reg;
    assign dq_out      = dq_reg;
    assign divisor_out = divisor_reg;

    `ASSERT_NEXT(a_cell_valid_moves, clk, rst_n, adv, ctl_reg.valid == $past(ctl_in.valid))

endmodule

`default_nettype wire

// ===== rtl/q24alu_outbuf.sv =====
// Result assembly and two-entry output buffer (main register plus skid).
// Depends on q24alu_pkg and q24alu_if.
`default_nettype none
`include "assert_macros.svh"

module q24alu_outbuf #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire q24alu_pkg::ctl_t      tail_ctl,
    input  wire logic [WORD_BITS-1:0]  tail_result,
    input  wire logic [WORD_BITS-1:0]  tail_quot,
    output logic                       adv,
    q24alu_out_if.source               res
);
    import q24alu_pkg::*;

    localparam int BW = WORD_BITS + 3;

    logic          main_valid_reg;
    logic          main_valid_next;
    logic [BW-1:0] main_data_reg;
    logic [BW-1:0] main_data_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic [BW-1:0] skid_data_reg;
    logic [BW-1:0] skid_data_next;

    logic [WORD_BITS-1:0] quot_signed;
    logic [WORD_BITS-1:0] fin_result;
    logic [BW-1:0]        fin_data;
    logic                 push;
    logic                 pop;

    assign quot_signed = tail_ctl.neg ? (~tail_quot + WORD_BITS'(1)) : tail_quot;

    always_comb begin
        priority if (tail_ctl.dz) begin
            fin_result = '0;
        end
        else if (tail_ctl.is_div) begin
            fin_result = quot_signed;
        end
        else begin
            fin_result = tail_result;
        end
    end

    assign fin_data = {fin_result, tail_ctl.less, tail_ctl.equal, tail_ctl.dz};

    // the chain moves only while the skid entry is free
    assign adv  = !skid_valid_reg;
    assign push = tail_ctl.valid && adv;
    assign pop  = main_valid_reg && res.ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_next = 1'b1;
                main_data_next  = fin_data;
            end
            else begin
                skid_valid_next = 1'b1;
                skid_data_next  = fin_data;
            end
        end
        else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res.valid    = main_valid_reg;
    assign res.result   = main_data_reg[BW-1:3];
    assign res.less     = main_data_reg[2];
    assign res.equal    = main_data_reg[1];
    assign res.div_zero = main_data_reg[0];

    `ASSERT_IMPLY(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg)
    `ASSERT_IMPLY(a_skid_fills_on_stall, clk, rst_n, $rose(skid_valid_reg), $past(main_valid_reg && !res.ready))

endmodule

`default_nettype wire

// ===== rtl/q24_8_fixed_point_alu.sv =====
// Q24.8 fixed-point ALU, top level.
// Depends on q24alu_pkg, q24alu_if, q24alu_front, q24alu_div_cell, q24alu_outbuf.
//
// Usage: one operation beat enters on op (kind, operand_a, operand_b) and one
// result beat leaves on res (result, less, equal, div_zero), in order.
// Operations: add, sub, mul, div, min, max, compare, inc, dec, int-to-fix and
// fix-to-int; codes 11 to 15 give result 0. Multiply drops FRAC_BITS fraction
// bits of the full product and keeps the next WORD_BITS bits; divide truncates
// toward zero and gives result 0 with div_zero set for a zero divisor.
// Throughput: one beat per cycle while the skid entry is free. Stages: an input
// register, the compute/multiply stage, one restoring-division cell per dividend
// bit, and the output register. Every operation runs through the same chain.
// Reset: clears all valid bits; op.ready is high right after reset.
// Stall: when res is held off, the output register keeps its beat and a skid
// entry catches the next one; while the skid entry is full the whole chain
// holds and op.ready is low. op.ready comes from a register only.
`default_nettype none

module q24_8_fixed_point_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    q24alu_in_if.sink        op,
    q24alu_out_if.source     res
);
    import q24alu_pkg::*;

    localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;

    logic adv;

    ctl_t                 chain_ctl     [DIV_STEPS+1];
    logic [WORD_BITS-1:0] chain_result  [DIV_STEPS+1];
    logic [WORD_BITS-1:0] chain_rem     [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] chain_dq      [DIV_STEPS+1];
    logic [WORD_BITS-1:0] chain_divisor [DIV_STEPS+1];

    q24alu_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .op      (op),
        .ctl     (chain_ctl[0]),
        .result  (chain_result[0]),
        .rem     (chain_rem[0]),
        .dq      (chain_dq[0]),
        .divisor (chain_divisor[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        q24alu_div_cell #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .ctl_in      (chain_ctl[i]),
            .result_in   (chain_result[i]),
            .rem_in      (chain_rem[i]),
            .dq_in       (chain_dq[i]),
            .divisor_in  (chain_divisor[i]),
            .ctl_out     (chain_ctl[i+1]),
            .result_out  (chain_result[i+1]),
            .rem_out     (chain_rem[i+1]),
            .dq_out      (chain_dq[i+1]),
            .divisor_out (chain_divisor[i+1])
        );
    end

    q24alu_outbuf #(
        .WORD_BITS (WORD_BITS)
    ) u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .tail_ctl    (chain_ctl[DIV_STEPS]),
        .tail_result (chain_result[DIV_STEPS]),
        .tail_quot   (chain_dq[DIV_STEPS][WORD_BITS-1:0]),
        .adv         (adv),
        .res         (res)
    );

endmodule

`default_nettype wire

// ===== tb/q24_8_fixed_point_alu_tb.sv =====
// Self-checking testbench for the Q24.8 fixed-point ALU: directed corners, then random beats.
// Depends on q24alu_pkg, q24alu_if and the q24_8_fixed_point_alu RTL.
`timescale 1ns / 1ps

module q24_8_fixed_point_alu_tb;

    import q24alu_pkg::*;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 8;
    localparam int RANDOM_OPS   = 1600;
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] ONE_FIX  = 1 << FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct {
        kind_t kind;
        word_t a;
        word_t b;
    } alu_op_t;

    typedef struct {
        alu_op_t op;
        word_t   result;
        logic    less;
        logic    equal;
        logic    div_zero;
    } alu_res_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_SPARSE
    } stall_mode_t;

    logic clk;
    logic rst_n;

    q24alu_in_if  #(.WORD_BITS(WORD_BITS)) op_if ();
    q24alu_out_if #(.WORD_BITS(WORD_BITS)) res_if ();

    q24_8_fixed_point_alu #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_if),
        .res   (res_if)
    );

    alu_op_t     op_backlog[$];
    alu_res_t    pending_results[$];
    alu_op_t     cur_op;
    alu_res_t    got_res;
    int          fail_cnt;
    int          burst_left;
    int          gap_left;
    int          stall_left;
    stall_mode_t stall_mode;
    logic        rdy_next;
    int          cycle_cnt;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bit-exact prediction of one operation.
    function automatic alu_res_t q24_compute(alu_op_t op);
        alu_res_t               r;
        logic signed [63:0]     sa;
        logic signed [63:0]     sb;
        logic signed [63:0]     prod;
        logic [63:0]            mag_a;
        logic [63:0]            mag_b;
        logic [63:0]            quo;
        r.op       = op;
        r.result   = '0;
        r.div_zero = 1'b0;
        r.less     = op.a < op.b;
        r.equal    = op.a == op.b;
        sa    = op.a;
        sb    = op.b;
        mag_a = sa[63] ? -sa : sa;
        mag_b = sb[63] ? -sb : sb;
        case (op.kind)
            KIND_ADD: r.result = op.a + op.b;
            KIND_SUB: r.result = op.a - op.b;
            KIND_MUL:
            begin
                prod     = sa * sb;
                r.result = prod[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
            end
            KIND_DIV:
            begin
                if (op.b == '0)
                    r.div_zero = 1'b1;
                else
                begin
                    quo = (mag_a << FRAC_BITS) / mag_b;
                    if (op.a[WORD_BITS-1] ^ op.b[WORD_BITS-1])
                        quo = -quo;
                    r.result = quo[WORD_BITS-1:0];
                end
            end
            KIND_MIN: r.result = (r.less || r.equal) ? op.a : op.b;
            KIND_MAX: r.result = r.less ? op.b : op.a;
            KIND_CMP: r.result = '0;
            KIND_INC: r.result = op.a + 1;
            KIND_DEC: r.result = op.a - 1;
            KIND_I2F: r.result = op.a << FRAC_BITS;
            KIND_F2I:
            begin
                // truncate toward zero on the magnitude
                quo = mag_a >> FRAC_BITS;
                if (op.a[WORD_BITS-1])
                    quo = -quo;
                r.result = quo[WORD_BITS-1:0];
            end
            default: r.result = '0;
        endcase
        return r;
    endfunction

    function automatic word_t rand_operand();
        case ($urandom_range(0, 9))
            4, 5: return word_t'(int'($urandom_range(0, 8191)) - 4096);
            6:
            begin
                case ($urandom_range(0, 7))
                    0: return '0;
                    1: return 1;
                    2: return -1;
                    3: return ONE_FIX;
                    4: return -ONE_FIX;
                    5: return WORD_MAX;
                    6: return WORD_MIN;
                    default: return WORD_MAX - 1;
                endcase
            end
            // whole and half units of moderate size
            7: return word_t'((int'($urandom_range(0, 65535)) - 32768) <<< (FRAC_BITS - 1));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic queue_op(kind_t kind, word_t a, word_t b);
        alu_op_t op;
        op.kind = kind;
        op.a    = a;
        op.b    = b;
        op_backlog.push_back(op);
    endtask

    // Sender: issue beats in bursts, with gaps between most bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_if.valid     <= 1'b0;
            op_if.kind      <= KIND_ADD;
            op_if.operand_a <= '0;
            op_if.operand_b <= '0;
            burst_left      = 1;
            gap_left        = 0;
        end
        else
        begin
            if (op_if.valid && op_if.ready)
                pending_results.push_back(q24_compute(cur_op));
            if (!op_if.valid || op_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    op_if.valid <= 1'b0;
                end
                else if (op_backlog.size() > 0)
                begin
                    cur_op = op_backlog.pop_front();
                    op_if.valid     <= 1'b1;
                    op_if.kind      <= cur_op.kind;
                    op_if.operand_a <= cur_op.a;
                    op_if.operand_b <= cur_op.b;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 5) == 0)
                        begin
                            burst_left = $urandom_range(100, 200);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = $urandom_range(1, 8);
                        end
                    end
                end
                else
                    op_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result beat, stall on a changing pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left   = 0;
            stall_mode   = RDY_ALWAYS;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fail_cnt < MAX_REPORTS)
                        $display("unexpected result beat: result=%h less=%b equal=%b div_zero=%b",
                                 res_if.result, res_if.less, res_if.equal, res_if.div_zero);
                    fail_cnt++;
                end
                else
                begin
                    got_res = pending_results.pop_front();
                    if (res_if.result !== got_res.result || res_if.less !== got_res.less ||
                        res_if.equal !== got_res.equal || res_if.div_zero !== got_res.div_zero)
                    begin
                        if (fail_cnt < MAX_REPORTS)
                            $display("mismatch kind=%0d a=%h b=%h: exp %h/%b%b%b got %h/%b%b%b",
                                     got_res.op.kind, got_res.op.a, got_res.op.b,
                                     got_res.result, got_res.less, got_res.equal,
                                     got_res.div_zero, res_if.result, res_if.less,
                                     res_if.equal, res_if.div_zero);
                        fail_cnt++;
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(50, 400);
            end
            else
                stall_left--;
            case (stall_mode)
                RDY_ALWAYS:   rdy_next = 1'b1;
                RDY_RANDOM:   rdy_next = 1'($urandom_range(0, 1));
                RDY_PERIODIC: rdy_next = (stall_left % 4) != 0;
                default:      rdy_next = $urandom_range(0, 7) == 0;
            endcase
            res_if.ready <= rdy_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        alu_op_t op;
        int      n;
        fail_cnt        = 0;
        cycle_cnt       = 0;
        op_if.valid     = 1'b0;
        op_if.kind      = KIND_ADD;
        op_if.operand_a = '0;
        op_if.operand_b = '0;
        res_if.ready    = 1'b0;
        rst_n           = 1'b0;

        // corners: wrap, full products, zero divisor, truncation, ties
        queue_op(KIND_ADD, WORD_MAX, 1);
        queue_op(KIND_ADD, WORD_MIN, WORD_MIN);
        queue_op(KIND_SUB, WORD_MIN, 1);
        queue_op(KIND_SUB, WORD_MAX, -1);
        queue_op(KIND_MUL, WORD_MAX, WORD_MAX);
        queue_op(KIND_MUL, WORD_MIN, WORD_MIN);
        queue_op(KIND_MUL, WORD_MIN, -ONE_FIX);
        queue_op(KIND_MUL, -1, 1);
        queue_op(KIND_DIV, ONE_FIX, '0);
        queue_op(KIND_DIV, WORD_MIN, -1);
        queue_op(KIND_DIV, WORD_MAX, 1);
        queue_op(KIND_DIV, -5 * ONE_FIX, 3 * ONE_FIX);
        queue_op(KIND_MIN, 7, 7);
        queue_op(KIND_MIN, WORD_MIN, WORD_MAX);
        queue_op(KIND_MAX, -3, -3);
        queue_op(KIND_MAX, WORD_MIN, WORD_MAX);
        queue_op(KIND_CMP, WORD_MAX, WORD_MIN);
        queue_op(KIND_INC, WORD_MAX, '0);
        queue_op(KIND_DEC, WORD_MIN, '0);
        queue_op(KIND_I2F, WORD_MAX, '0);
        queue_op(KIND_I2F, WORD_MIN, '0);
        queue_op(KIND_F2I, -1, '0);
        queue_op(KIND_F2I, WORD_MIN, '0);
        queue_op(kind_t'(11), 5, 9);
        queue_op(kind_t'(15), WORD_MAX, WORD_MAX);

        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if ($urandom_range(0, 99) < 6)
                op.kind = kind_t'($urandom_range(11, 15));
            else
                op.kind = kind_t'($urandom_range(0, 10));
            op.a = rand_operand();
            if ($urandom_range(0, 7) == 0)
                op.b = op.a;
            else if (op.kind == KIND_DIV && $urandom_range(0, 9) == 0)
                op.b = '0;
            else
                op.b = rand_operand();
            op_backlog.push_back(op);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (op_backlog.size() != 0 || op_if.valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/q24alu_pkg.sv
rtl/q24alu_if.sv
rtl/q24alu_front.sv
rtl/q24alu_div_cell.sv
rtl/q24alu_outbuf.sv
rtl/q24_8_fixed_point_alu.sv
tb/q24_8_fixed_point_alu_tb.sv
